### rtl/adpfp_pkg.sv
// ----------------------------------------------------------------------------
// adpfp_pkg: shared constants and types
// Byte codes, request kinds and lane control for the decimal parameter parser.
// ----------------------------------------------------------------------------
package adpfp_pkg;

   // request kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // framing characters
   localparam logic [7:0] CH_START   = 8'h2A;  // '*'
   localparam logic [7:0] CH_END     = 8'h23;  // '#'
   localparam logic [7:0] CH_SEP     = 8'h2D;  // '-'
   localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'

   localparam int unsigned SCALE_TEN = 10;

   // result value ports
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned NUM_VALUES = 5;

   // parameter defaults
   localparam int unsigned NUM_FIELDS_DEF  = 5;
   localparam int unsigned FIELD_WIDTH_DEF = 16;

   typedef struct packed {
      logic take_digit;  // a digit byte inside a frame
      logic scale_ten;   // multiply the running value by ten first
      logic clear_all;   // read request: clear every accumulator
   } lane_ctrl_type;

endpackage

### rtl/adpfp_field_acc.sv
// ----------------------------------------------------------------------------
// adpfp_field_acc: one parameter accumulator
// Folds a decimal digit into the running value (acc*scale + digit) and
// clears on a read.
// ----------------------------------------------------------------------------
module adpfp_field_acc #(
   parameter int unsigned FIELD_WIDTH = adpfp_pkg::FIELD_WIDTH_DEF,
   parameter int unsigned IDX_W       = 3,
   parameter int unsigned LANE_ID     = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  adpfp_pkg::lane_ctrl_type  ctrl,
   input  logic [IDX_W-1:0]          field_index,
   input  logic [7:0]                rx_byte,
   output logic [FIELD_WIDTH-1:0]    acc_cur,
   output logic [FIELD_WIDTH-1:0]    acc_next
);
   import adpfp_pkg::*;

   logic [FIELD_WIDTH-1:0] acc_ff;
   logic [FIELD_WIDTH-1:0] acc_in;
   logic [FIELD_WIDTH-1:0] digit;
   logic [FIELD_WIDTH-1:0] scaled;
   logic                   sel;

   // non-digit bytes wrap like any other digit value
   assign digit  = FIELD_WIDTH'(rx_byte) - FIELD_WIDTH'(DIGIT_BASE);
   assign scaled = ctrl.scale_ten ? FIELD_WIDTH'(acc_ff * FIELD_WIDTH'(SCALE_TEN)) : acc_ff;
   assign sel    = (field_index == IDX_W'(LANE_ID));

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear_all) begin
         acc_in = '0;
      end else if (ctrl.take_digit && sel) begin
         acc_in = scaled + digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc_cur  = acc_ff;
   assign acc_next = acc_in;

endmodule

### rtl/ascii_decimal_param_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_decimal_param_frame_parser: ASCII decimal parameter frame parser
// Parses '*' d..d - d..d ... '#' frames of decimal parameters from UART bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request: a received byte (req_kind = 0,
//   req_rx_byte) or a read of all parameters (req_kind = 1). Each request
//   gives exactly one result on the rsp_ channel: rsp_frame_done is set
//   when the byte closed a frame, and rsp_value_a..e hold the parameters,
//   after the byte's update, or for a read the values before the clear.
//   Results are registered: a request accepted at an edge has its result
//   valid right after that edge. One request per cycle unless stalled; the
//   frame state and accumulators update in a single pass at acceptance,
//   bounded by one multiply-by-ten and add on a FIELD_WIDTH accumulator.
//   The result register accepts a new request in the same cycle its
//   result is taken; while rsp_ready is low and a result is held,
//   req_ready drops and nothing is lost.
//   Reset leaves the frame, zeroes the field index, scale and all
//   accumulators, and empties the result register.
// ----------------------------------------------------------------------------
module ascii_decimal_param_frame_parser #(
   parameter int unsigned NUM_FIELDS  = adpfp_pkg::NUM_FIELDS_DEF,
   parameter int unsigned FIELD_WIDTH = adpfp_pkg::FIELD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_frame_done,
   output logic [adpfp_pkg::VALUE_W-1:0]   rsp_value_a,
   output logic [adpfp_pkg::VALUE_W-1:0]   rsp_value_b,
   output logic [adpfp_pkg::VALUE_W-1:0]   rsp_value_c,
   output logic [adpfp_pkg::VALUE_W-1:0]   rsp_value_d,
   output logic [adpfp_pkg::VALUE_W-1:0]   rsp_value_e
);
   import adpfp_pkg::*;

   localparam int unsigned IDX_W = $clog2(NUM_FIELDS + 1);

   logic               accept;
   logic               in_frame_ff, in_frame_in;
   logic [IDX_W-1:0]   field_index_ff, field_index_in;
   logic               scale_ten_ff, scale_ten_in;
   logic               done;
   lane_ctrl_type      ctrl;

   logic [FIELD_WIDTH-1:0] acc_cur  [NUM_FIELDS];
   logic [FIELD_WIDTH-1:0] acc_next [NUM_FIELDS];
   logic [VALUE_W-1:0]     value    [NUM_VALUES];

   logic               rsp_valid_ff;
   logic               frame_done_ff;
   logic [VALUE_W-1:0] value_ff [NUM_VALUES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // frame tracking
   always_comb begin
      in_frame_in     = in_frame_ff;
      field_index_in  = field_index_ff;
      scale_ten_in    = scale_ten_ff;
      done            = 1'b0;
      ctrl.take_digit = 1'b0;
      ctrl.scale_ten  = scale_ten_ff;
      ctrl.clear_all  = accept && (req_kind == KIND_READ);
      if (accept && (req_kind == KIND_BYTE)) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == CH_START) begin
               in_frame_in = 1'b1;
            end
         end else if (req_rx_byte == CH_END || req_rx_byte == CH_START) begin
            in_frame_in    = 1'b0;
            field_index_in = '0;
            scale_ten_in   = 1'b0;
            done           = (req_rx_byte == CH_END);
         end else if (req_rx_byte == CH_SEP) begin
            // index saturates at NUM_FIELDS; later digits hit no lane
            if (field_index_ff < IDX_W'(NUM_FIELDS)) begin
               field_index_in = field_index_ff + 1'b1;
            end
            scale_ten_in = 1'b0;
         end else begin
            ctrl.take_digit = 1'b1;
            scale_ten_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         field_index_ff <= '0;
         scale_ten_ff   <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         field_index_ff <= field_index_in;
         scale_ten_ff   <= scale_ten_in;
      end
   end

   for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_lane
      adpfp_field_acc #(
         .FIELD_WIDTH (FIELD_WIDTH),
         .IDX_W       (IDX_W),
         .LANE_ID     (i)
      ) u_acc (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .field_index (field_index_ff),
         .rx_byte     (req_rx_byte),
         .acc_cur     (acc_cur[i]),
         .acc_next    (acc_next[i])
      );
   end

   // a read reports the values before its clear
   for (genvar i = 0; i < NUM_VALUES; i++) begin : g_value
      if (i < NUM_FIELDS) begin : g_used
         assign value[i] = (req_kind == KIND_READ) ? VALUE_W'(acc_cur[i])
                                                   : VALUE_W'(acc_next[i]);
      end else begin : g_absent
         assign value[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_done_ff <= done;
         value_ff      <= value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_done = frame_done_ff;
   assign rsp_value_a    = value_ff[0];
   assign rsp_value_b    = value_ff[1];
   assign rsp_value_c    = value_ff[2];
   assign rsp_value_d    = value_ff[3];
   assign rsp_value_e    = value_ff[4];

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: ascii_decimal_param_frame_parser
// Streams framed decimal parameter bytes and read requests into the parser,
// predicts every response in step with acceptance and checks each field.
// Both channels run with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
   import adpfp_pkg::*;

   localparam int unsigned NF = NUM_FIELDS_DEF;
   localparam int unsigned FW = FIELD_WIDTH_DEF;
   localparam int unsigned TARGET_REQS = 1800;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx;
   } request_type;

   typedef struct packed {
      logic                                  done;
      logic [NUM_VALUES-1:0][VALUE_W-1:0]    value;
   } param_result_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_kind;
   logic [7:0]       req_rx_byte;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_frame_done;
   logic [VALUE_W-1:0] rsp_value_a;
   logic [VALUE_W-1:0] rsp_value_b;
   logic [VALUE_W-1:0] rsp_value_c;
   logic [VALUE_W-1:0] rsp_value_d;
   logic [VALUE_W-1:0] rsp_value_e;

   ascii_decimal_param_frame_parser uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_done (rsp_frame_done),
      .rsp_value_a    (rsp_value_a),
      .rsp_value_b    (rsp_value_b),
      .rsp_value_c    (rsp_value_c),
      .rsp_value_d    (rsp_value_d),
      .rsp_value_e    (rsp_value_e)
   );

   // parser shadow state
   logic          frame_open;
   int unsigned   param_sel;
   logic          ten_next;
   logic [FW-1:0] param_acc [NF];

   request_type      pending_reqs[$];
   param_result_type expected_params[$];

   int unsigned   mismatches;
   int unsigned   stim_count;
   int unsigned   reqs_taken;
   int unsigned   rsps_checked;
   int unsigned   reads_taken;
   int unsigned   frames_closed;

   bit            req_took;
   bit            holding;
   int            req_gap;
   int            req_calm;
   int            rsp_stall;
   int            rsp_calm;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // mostly short gaps, a few long ones, and now and then a run without any
   function automatic int gap_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 99) == 0) begin
         calm = $urandom_range(30, 150);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic void leave_frame();
      frame_open = 1'b0;
      param_sel  = 0;
      ten_next   = 1'b0;
   endfunction

   function automatic param_result_type advance_parser(logic kind, logic [7:0] rx);
      param_result_type res;
      logic [FW-1:0] digit;
      logic [FW-1:0] run;
      res = '0;
      if (kind == KIND_BYTE) begin
         if (!frame_open) begin
            if (rx == CH_START) frame_open = 1'b1;
         end else if (rx == CH_END) begin
            leave_frame();
            res.done = 1'b1;
         end else if (rx == CH_START) begin
            leave_frame();
         end else if (rx == CH_SEP) begin
            if (param_sel < NF) param_sel++;
            ten_next = 1'b0;
         end else begin
            // anything else is taken as a digit, wrapping below '0'
            if (param_sel < NF) begin
               digit = FW'(rx) - FW'(DIGIT_BASE);
               run   = param_acc[param_sel];
               if (ten_next) run = FW'(run * SCALE_TEN);
               param_acc[param_sel] = run + digit;
            end
            ten_next = 1'b1;
         end
      end
      for (int i = 0; i < NUM_VALUES; i++) begin
         if (i < NF) res.value[i] = VALUE_W'(param_acc[i]);
      end
      if (kind == KIND_READ) begin
         for (int i = 0; i < NF; i++) param_acc[i] = '0;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] seen);
      mismatches++;
      $display("%0t mismatch %s: expected %h got %h", $time, what, want, seen);
   endtask

   task automatic push_req(logic kind, logic [7:0] rx, bit counted);
      request_type r;
      r.kind = kind;
      r.rx   = rx;
      pending_reqs.push_back(r);
      if (counted) stim_count++;
   endtask

   task automatic push_digits(int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0) push_req(KIND_BYTE, 8'($urandom_range(0, 255)), 1);
         else push_req(KIND_BYTE, DIGIT_BASE + 8'($urandom_range(0, 9)), 1);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_took) begin
            req_took = 1'b0;
            holding  = 1'b0;
         end
         if (!holding) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= nxt.kind;
               req_rx_byte <= nxt.rx;
               holding = 1'b1;
               req_gap = gap_len(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = gap_len(rsp_calm);
      end
   end

   // monitor: predict on request acceptance, check on response acceptance
   always @(posedge clock) begin
      param_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_params.size() == 0) begin
               report_mismatch("pending responses", 32'd0, 32'd1);
            end else begin
               want = expected_params.pop_front();
               rsps_checked++;
               if (rsp_frame_done !== want.done)
                  report_mismatch("frame_done", want.done, rsp_frame_done);
               if (rsp_value_a !== want.value[0])
                  report_mismatch("value_a", want.value[0], rsp_value_a);
               if (rsp_value_b !== want.value[1])
                  report_mismatch("value_b", want.value[1], rsp_value_b);
               if (rsp_value_c !== want.value[2])
                  report_mismatch("value_c", want.value[2], rsp_value_c);
               if (rsp_value_d !== want.value[3])
                  report_mismatch("value_d", want.value[3], rsp_value_d);
               if (rsp_value_e !== want.value[4])
                  report_mismatch("value_e", want.value[4], rsp_value_e);
            end
         end
         if (req_valid && req_ready) begin
            want = advance_parser(req_kind, req_rx_byte);
            expected_params.push_back(want);
            reqs_taken++;
            if (req_kind == KIND_READ) reads_taken++;
            if (want.done) frames_closed++;
            req_took = 1'b1;
         end
      end
   end

   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int r;
      int nparams;
      int tail;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = KIND_BYTE;
      req_rx_byte = 8'h00;
      rsp_ready   = 1'b0;
      mismatches = 0;
      stim_count = 0;
      reqs_taken = 0;
      rsps_checked = 0;
      reads_taken = 0;
      frames_closed = 0;
      req_took = 1'b0;
      holding  = 1'b0;
      req_gap  = 0;
      req_calm = 0;
      rsp_stall = 0;
      rsp_calm  = 0;
      leave_frame();
      for (int i = 0; i < NF; i++) param_acc[i] = '0;

      // directed: read at reset, bytes outside a frame, wrap-around digits,
      // separator saturation, extra parameter, close, abort and reopen
      push_req(KIND_READ, 8'hFF, 1);
      push_req(KIND_BYTE, "7", 1);
      push_req(KIND_BYTE, CH_END, 1);
      push_req(KIND_BYTE, CH_START, 1);
      push_req(KIND_BYTE, "1", 1);
      push_req(KIND_BYTE, "2", 1);
      push_req(KIND_BYTE, CH_SEP, 1);
      push_req(KIND_BYTE, 8'h00, 1);
      push_req(KIND_BYTE, 8'hFF, 1);
      push_req(KIND_BYTE, CH_SEP, 1);
      push_req(KIND_BYTE, "7", 1);
      push_req(KIND_BYTE, "0", 1);
      push_req(KIND_BYTE, "0", 1);
      push_req(KIND_BYTE, "0", 1);
      push_req(KIND_BYTE, "0", 1);
      for (int k = 0; k < 4; k++) push_req(KIND_BYTE, CH_SEP, 1);
      push_req(KIND_BYTE, "8", 1);
      push_req(KIND_BYTE, CH_END, 1);
      push_req(KIND_READ, 8'h00, 1);
      push_req(KIND_BYTE, CH_START, 1);
      push_req(KIND_BYTE, "3", 1);
      push_req(KIND_BYTE, CH_START, 1);
      push_req(KIND_BYTE, "4", 1);
      push_req(KIND_BYTE, CH_START, 1);
      push_req(KIND_BYTE, CH_END, 1);
      push_req(KIND_READ, 8'hA5, 1);

      // random: mostly well-formed frames, some reads, some line noise
      while (stim_count < TARGET_REQS) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            push_req(KIND_BYTE, CH_START, 1);
            nparams = $urandom_range(0, 7);
            for (int f = 0; f < nparams; f++) begin
               if (f > 0) push_req(KIND_BYTE, CH_SEP, 1);
               push_digits($urandom_range(0, 5));
            end
            tail = $urandom_range(0, 9);
            if (tail < 8) push_req(KIND_BYTE, CH_END, 1);
            else if (tail == 8) push_req(KIND_BYTE, CH_START, 1);
            if ($urandom_range(0, 9) < 4) push_req(KIND_READ, 8'($urandom_range(0, 255)), 1);
         end else if (r < 82) begin
            push_req(KIND_READ, 8'($urandom_range(0, 255)), 1);
         end else begin
            for (int k = $urandom_range(1, 4); k > 0; k--)
               push_req(KIND_BYTE, 8'($urandom_range(0, 255)), 0);
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || holding) @(posedge clock);
      while (expected_params.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("covered %0d requests (%0d reads), %0d responses checked, %0d frames closed",
               reqs_taken, reads_taken, rsps_checked, frames_closed);
      $display("random gaps on both channels, %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
